>>> src/twsm_pkg.sv
// Shared types and constants for the three-wire serial master.
// No dependencies; used by three_wire_serial_master.
`default_nettype none

package twsm_pkg;

  localparam int unsigned RegW      = 8;
  localparam int unsigned BitCountW = 5;
  localparam int unsigned TxW       = 16;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 16;

  localparam logic [RegW-1:0] HalfBitReset = 8'd2;
  localparam logic [RegW-1:0] SetupReset   = 8'd5;
  localparam logic [RegW-1:0] TickMax      = 8'hFF;

  // Bits per transfer: address plus data on a write, address alone before a read.
  localparam logic [BitCountW-1:0] WriteBits = 5'd16;
  localparam logic [BitCountW-1:0] ReadTxBits = 5'd8;
  localparam logic [BitCountW-1:0] RxBits    = 5'd8;

  // Input word kinds (tuser).
  localparam logic KindStart = 1'b0;
  localparam logic KindTick  = 1'b1;

  // Configuration register indexes.
  localparam logic RegHalfBit = 1'b0;
  localparam logic RegSetup   = 1'b1;

  typedef enum logic [6:0] {
    PhIdle   = 7'b0000001,
    PhSetup1 = 7'b0000010,
    PhSetup2 = 7'b0000100,
    PhTxLow  = 7'b0001000,
    PhTxHigh = 7'b0010000,
    PhRxLow  = 7'b0100000,
    PhRxHigh = 7'b1000000
  } phase_e;

endpackage

`default_nettype wire

>>> src/three_wire_serial_master.sv
// Three-wire serial master: sequencer, pin state and result register.
// Depends on twsm_pkg for phase encoding, widths and register indexes.
//
// Usage: each input word on the s_axis channel is either a start (tuser = 0) that
// loads read/write, address and write byte, or a tick (tuser = 1) that advances the
// bit sequencer one step and carries the sampled data-line level. Every accepted word
// produces exactly one result word on m_axis with the pin levels (enable, clock, data
// out, data drive), the last finished read byte and done/busy/rejected flags.
// A start while a transfer runs is flagged rejected and otherwise ignored.
// The result is registered and appears in the output register the cycle after the
// word is accepted. Throughput is one word per cycle while m_axis is not stalled, set
// by the single pass through the sequencer logic between the state registers and the
// output register. s_axis_tready_o is high while the output register is empty or being
// drained, so a stalled receiver holds the result and stops intake after one word.
// Reset (rst_ni low) returns the sequencer to idle, pins low with data driven, read
// byte zero, timing registers to half_bit_ticks = 2 and enable_setup_ticks = 5.
// Configuration writes (cfg_we_i) take effect at once; the user must make them while idle, unchecked by the block.
`default_nettype none

module three_wire_serial_master (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Input words
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [0] is_read, [8:1] address, [16:9] write_data, [17] io_in, [23:18] zero
  input  wire  [twsm_pkg::InDataW-1:0]        s_axis_tdata_i,
  // [0] kind
  input  wire                                 s_axis_tuser_i,
  // Result words
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // [0] enable_pin, [1] clock_pin, [2] io_out, [3] io_drive, [11:4] read_data,
  // [12] done_res, [13] busy_res, [14] rejected, [15] zero
  output logic [twsm_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // Configuration
  input  wire                                 cfg_we_i,
  input  wire                                 cfg_idx_i,
  input  wire  [twsm_pkg::RegW-1:0]           cfg_data_i
);

  logic [twsm_pkg::RegW-1:0]      half_bit_q, setup_q;
  twsm_pkg::phase_e               phase_q, phase_d;
  logic [twsm_pkg::BitCountW-1:0] bit_cnt_q, bit_cnt_d;
  logic [twsm_pkg::RegW-1:0]      tick_cnt_q, tick_cnt_d;
  logic [twsm_pkg::TxW-1:0]       tx_shift_q, tx_shift_d;
  logic [7:0]                     rx_shift_q, rx_shift_d;
  logic                           read_flag_q, read_flag_d;
  logic                           en_q, en_d, clk_pin_q, clk_pin_d;
  logic                           io_q, io_d, drive_q, drive_d;
  logic [7:0]                     last_rd_q, last_rd_d;
  logic                           done, rejected;

  logic                           in_acc;
  logic                           in_is_read, in_io;
  logic [7:0]                     in_addr, in_wdata;

  logic [twsm_pkg::RegW-1:0]      wait_lim, lim_eff, tick_inc;
  logic                           wait_done;
  logic [twsm_pkg::BitCountW-1:0] bit_inc;
  logic [twsm_pkg::TxW-1:0]       tx_next;

  logic [twsm_pkg::OutDataW-1:0]  out_d;

  assign s_axis_tready_o = ~m_axis_tvalid_o | m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  assign in_is_read = s_axis_tdata_i[0];
  assign in_addr    = s_axis_tdata_i[8:1];
  assign in_wdata   = s_axis_tdata_i[16:9];
  assign in_io      = s_axis_tdata_i[17];

  // Setup phases time against enable_setup_ticks, bit halves against half_bit_ticks.
  assign wait_lim  = (phase_q == twsm_pkg::PhSetup1 || phase_q == twsm_pkg::PhSetup2)
                     ? setup_q : half_bit_q;
  assign lim_eff   = (wait_lim == '0) ? twsm_pkg::RegW'(1) : wait_lim;
  assign tick_inc  = (tick_cnt_q == twsm_pkg::TickMax) ? tick_cnt_q
                     : tick_cnt_q + twsm_pkg::RegW'(1);
  assign wait_done = (tick_inc >= lim_eff);
  assign bit_inc   = bit_cnt_q + twsm_pkg::BitCountW'(1);
  assign tx_next   = tx_shift_q >> 1;

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    tick_cnt_d  = tick_cnt_q;
    tx_shift_d  = tx_shift_q;
    rx_shift_d  = rx_shift_q;
    read_flag_d = read_flag_q;
    en_d        = en_q;
    clk_pin_d   = clk_pin_q;
    io_d        = io_q;
    drive_d     = drive_q;
    last_rd_d   = last_rd_q;
    done        = 1'b0;
    rejected    = 1'b0;

    if (s_axis_tuser_i == twsm_pkg::KindStart) begin
      if (phase_q != twsm_pkg::PhIdle) begin
        rejected = 1'b1;
      end else begin
        read_flag_d = in_is_read;
        tx_shift_d  = {in_wdata, in_addr};
        bit_cnt_d   = '0;
        tick_cnt_d  = '0;
        en_d        = 1'b0;
        clk_pin_d   = 1'b0;
        io_d        = 1'b0;
        drive_d     = 1'b1;
        phase_d     = twsm_pkg::PhSetup1;
      end
    end else if (phase_q != twsm_pkg::PhIdle) begin
      tick_cnt_d = wait_done ? '0 : tick_inc;
      if (wait_done) begin
        unique case (phase_q)
          twsm_pkg::PhSetup1: begin
            en_d    = 1'b1;
            phase_d = twsm_pkg::PhSetup2;
          end
          twsm_pkg::PhSetup2: begin
            clk_pin_d = 1'b0;
            io_d      = tx_shift_q[0];
            phase_d   = twsm_pkg::PhTxLow;
          end
          twsm_pkg::PhTxLow: begin
            clk_pin_d = 1'b1;
            phase_d   = twsm_pkg::PhTxHigh;
          end
          twsm_pkg::PhTxHigh: begin
            tx_shift_d = tx_next;
            bit_cnt_d  = bit_inc;
            if (bit_inc >= (read_flag_q ? twsm_pkg::ReadTxBits : twsm_pkg::WriteBits)) begin
              if (!read_flag_q) begin
                done = 1'b1;
              end else begin
                // turn the data line around for the read byte
                drive_d    = 1'b0;
                io_d       = 1'b0;
                clk_pin_d  = 1'b0;
                bit_cnt_d  = '0;
                rx_shift_d = '0;
                phase_d    = twsm_pkg::PhRxLow;
              end
            end else begin
              clk_pin_d = 1'b0;
              io_d      = tx_next[0];
              phase_d   = twsm_pkg::PhTxLow;
            end
          end
          twsm_pkg::PhRxLow: begin
            rx_shift_d = {in_io, rx_shift_q[7:1]};
            clk_pin_d  = 1'b1;
            phase_d    = twsm_pkg::PhRxHigh;
          end
          twsm_pkg::PhRxHigh: begin
            bit_cnt_d = bit_inc;
            if (bit_inc >= twsm_pkg::RxBits) begin
              last_rd_d = rx_shift_q;
              done      = 1'b1;
            end else begin
              clk_pin_d = 1'b0;
              phase_d   = twsm_pkg::PhRxLow;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
        // end of transfer: drop enable and clock, drive data low
        if (done) begin
          en_d       = 1'b0;
          clk_pin_d  = 1'b0;
          io_d       = 1'b0;
          drive_d    = 1'b1;
          phase_d    = twsm_pkg::PhIdle;
          bit_cnt_d  = '0;
          tick_cnt_d = '0;
        end
      end
    end

    out_d = {1'b0, rejected, (phase_d != twsm_pkg::PhIdle), done, last_rd_d,
             drive_d, io_d, clk_pin_d, en_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q <= twsm_pkg::HalfBitReset;
      setup_q    <= twsm_pkg::SetupReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        twsm_pkg::RegHalfBit: half_bit_q <= cfg_data_i;
        twsm_pkg::RegSetup:   setup_q    <= cfg_data_i;
        default:              half_bit_q <= half_bit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= twsm_pkg::PhIdle;
      bit_cnt_q   <= '0;
      tick_cnt_q  <= '0;
      tx_shift_q  <= '0;
      rx_shift_q  <= '0;
      read_flag_q <= 1'b0;
      en_q        <= 1'b0;
      clk_pin_q   <= 1'b0;
      io_q        <= 1'b0;
      drive_q     <= 1'b1;
      last_rd_q   <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      tick_cnt_q  <= tick_cnt_d;
      tx_shift_q  <= tx_shift_d;
      rx_shift_q  <= rx_shift_d;
      read_flag_q <= read_flag_d;
      en_q        <= en_d;
      clk_pin_q   <= clk_pin_d;
      io_q        <= io_d;
      drive_q     <= drive_d;
      last_rd_q   <= last_rd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (s_axis_tready_o) begin
      m_axis_tvalid_o <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_axis_tdata_o <= out_d;
    end
  end

  // Released data line only happens inside a read, with enable high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[3]) |-> (m_axis_tdata_o[0] && m_axis_tdata_o[13]))
    else $error("data line released outside an active read");

  // Idle result words show the pins parked: enable and clock low, data driven low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[13]) |->
      (!m_axis_tdata_o[0] && !m_axis_tdata_o[1] && !m_axis_tdata_o[2] && m_axis_tdata_o[3]))
    else $error("pins not parked while idle");

  // A finishing word reports idle, and a rejected start only happens while busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!(m_axis_tdata_o[12] && m_axis_tdata_o[13]) &&
                         !(m_axis_tdata_o[14] && !m_axis_tdata_o[13])))
    else $error("done/busy/rejected flags inconsistent");

  // An accepted start while idle moves the sequencer into the first setup wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == twsm_pkg::KindStart && phase_q == twsm_pkg::PhIdle)
      |=> (phase_q == twsm_pkg::PhSetup1))
    else $error("start from idle did not enter setup");

endmodule

`default_nettype wire
